// ===== hdl/dll_pkg.sv =====
// ============================================================================
// dll_pkg - shared types and constants for the linked list engine
// Action and status codes, stream packing widths and node RAM control.
// ============================================================================
`default_nettype none

package dll_pkg;

  // Default node store size
  localparam int unsigned CAPACITY_DEF = 16;

  // Field widths
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned POS_W  = 5;

  // Stream data widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND   = 3'd0,
    ACT_SEARCH   = 3'd1,
    ACT_DELETE   = 3'd2,
    ACT_DUMP_FWD = 3'd3,
    ACT_DUMP_BWD = 3'd4
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_FOUND    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_DELETED  = 3'd4,
    ST_FULL     = 3'd5,
    ST_ELEM     = 3'd6
  } status_e;

  // Node RAM control: write enables per field and read enable
  typedef struct packed {
    logic val_we;
    logic next_we;
    logic prev_we;
    logic rd_en;
  } dll_ram_ctl_t;

endpackage : dll_pkg

`default_nettype wire

// ===== hdl/dll_node_ram.sv =====
// ============================================================================
// dll_node_ram - node store of the linked list engine
// Value, forward link and backward link arrays, each with its own write
// port, sharing one registered read port.
// ============================================================================
`default_nettype none

module dll_node_ram
  import dll_pkg::*;
#(
  parameter int unsigned Depth = CAPACITY_DEF,
  parameter int unsigned IdxW  = $clog2(CAPACITY_DEF + 1)
) (
  input  wire logic                        clk_i,
  input  wire dll_ram_ctl_t                ctl_i,
  input  wire logic [$clog2(Depth)-1:0]    val_addr_i,
  input  wire logic [DATA_W-1:0]           val_data_i,
  input  wire logic [$clog2(Depth)-1:0]    next_addr_i,
  input  wire logic [IdxW-1:0]             next_data_i,
  input  wire logic [$clog2(Depth)-1:0]    prev_addr_i,
  input  wire logic [IdxW-1:0]             prev_data_i,
  input  wire logic [$clog2(Depth)-1:0]    rd_addr_i,
  output logic      [DATA_W-1:0]           rd_val_o,
  output logic      [IdxW-1:0]             rd_next_o,
  output logic      [IdxW-1:0]             rd_prev_o
);

  logic [DATA_W-1:0] val_mem  [Depth];
  logic [IdxW-1:0]   next_mem [Depth];
  logic [IdxW-1:0]   prev_mem [Depth];

  // Write ports
  always_ff @(posedge clk_i) begin
    if (ctl_i.val_we) begin
      val_mem[val_addr_i] <= val_data_i;
    end
    if (ctl_i.next_we) begin
      next_mem[next_addr_i] <= next_data_i;
    end
    if (ctl_i.prev_we) begin
      prev_mem[prev_addr_i] <= prev_data_i;
    end
  end

  // Shared read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_val_o  <= val_mem[rd_addr_i];
      rd_next_o <= next_mem[rd_addr_i];
      rd_prev_o <= prev_mem[rd_addr_i];
    end
  end

endmodule : dll_node_ram

`default_nettype wire

// ===== hdl/doubly_linked_list_engine_core.sv =====
// Results: append, full and empty results are set in S_START and registered.
// Search/delete walk from the head to the first match or to the tail.
// Dumps: after the walk starts, one element per cycle unless stalled.
// Throughput: one item at a time; walks read one node per cycle through the
// single node RAM read port; a dump walk waits while the output is stalled.
// Reset: rst_ni returns to S_IDLE, sets head and tail to Nil and clears count, node-used flags and the output valid.
// ============================================================================
// doubly_linked_list_engine_core - bounded doubly linked list engine
// Node values and links live in a synchronous RAM; head, tail, count and the
// per-node used flags are registers. Walks follow links one node per cycle when not stalled.
// ============================================================================
`default_nettype none

module doubly_linked_list_engine_core
  import dll_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // tdata: [2:0] action, [34:3] value, [39:35] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: [2:0] status, [34:3] value_res, [39:35] position
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tvalid,
  output logic                        m_axis_tlast,
  input  wire logic                   m_axis_tready
);

  localparam int unsigned IdxW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam logic [IdxW-1:0] Nil = IdxW'(CAPACITY);
  localparam logic [IdxW-1:0] One = IdxW'(1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_START = 3'b010,
    S_WALK  = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  action_e                   act_q, act_d;
  logic signed [DATA_W-1:0]  val_q, val_d;
  logic [IdxW-1:0]           cur_q, cur_d;
  logic [IdxW-1:0]           pos_q, pos_d;
  logic [IdxW-1:0]           head_q, head_d;
  logic [IdxW-1:0]           tail_q, tail_d;
  logic [IdxW-1:0]           count_q, count_d;
  logic [CAPACITY-1:0]       used_q, used_d;

  logic                      out_valid_q, out_valid_d;
  status_e                   out_status_q, out_status_d;
  logic [DATA_W-1:0]         out_value_q, out_value_d;
  logic [POS_W-1:0]          out_pos_q, out_pos_d;
  logic                      out_last_q, out_last_d;

  logic                      s_accept;
  logic                      slot_free;
  logic [IdxW-1:0]           free_idx;

  // Node RAM interface
  dll_ram_ctl_t              ram_ctl;
  logic [AddrW-1:0]          val_addr, next_addr, prev_addr, rd_addr;
  logic [IdxW-1:0]           next_wdata, prev_wdata;
  logic [DATA_W-1:0]         rd_val;
  logic [IdxW-1:0]           rd_next, rd_prev;

  // Walk helpers
  logic                      is_fwd;
  logic                      match;
  logic                      at_end;
  logic [IdxW-1:0]           step_idx;
  logic [IdxW-1:0]           pv_idx, nx_idx;

  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign slot_free     = ~out_valid_q | m_axis_tready;

  // Lowest unused node
  always_comb begin
    free_idx = Nil;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  // Walk decode on the node just read
  assign is_fwd   = (act_q != ACT_DUMP_BWD);
  assign match    = (rd_val == val_q);
  assign at_end   = (cur_q == (is_fwd ? tail_q : head_q)) || (pos_q == Nil);
  assign step_idx = is_fwd ? rd_next : rd_prev;
  assign pv_idx   = (cur_q == head_q) ? Nil : rd_prev;
  assign nx_idx   = (cur_q == tail_q) ? Nil : rd_next;

  // Control and datapath
  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    val_d        = val_q;
    cur_d        = cur_q;
    pos_d        = pos_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    used_d       = used_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_pos_d    = out_pos_q;
    out_last_d   = out_last_q;
    ram_ctl      = '0;
    val_addr     = free_idx[AddrW-1:0];
    next_addr    = tail_q[AddrW-1:0];
    next_wdata   = free_idx;
    prev_addr    = free_idx[AddrW-1:0];
    prev_wdata   = tail_q;
    rd_addr      = head_q[AddrW-1:0];

    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          act_d   = action_e'(s_axis_tdata[ACT_W-1:0]);
          val_d   = s_axis_tdata[ACT_W +: DATA_W];
          state_d = S_START;
        end
      end

      S_START: begin
        if (slot_free) begin
          out_value_d  = val_q;
          out_pos_d    = '0;
          out_last_d   = 1'b1;
          case (act_q)
            ACT_APPEND: begin
              out_valid_d = 1'b1;
              state_d     = S_IDLE;
              if (count_q >= Nil || free_idx == Nil) begin
                out_status_d = ST_FULL;
              end else begin
                out_status_d     = ST_ADDED;
                ram_ctl.val_we   = 1'b1;
                ram_ctl.prev_we  = 1'b1;
                ram_ctl.next_we  = (tail_q != Nil);
                if (tail_q == Nil) begin
                  head_d = free_idx;
                end
                tail_d   = free_idx;
                count_d  = count_q + One;
                used_d[free_idx[AddrW-1:0]] = 1'b1;
              end
            end
            ACT_SEARCH, ACT_DELETE, ACT_DUMP_FWD, ACT_DUMP_BWD: begin
              if (head_q == Nil) begin
                out_valid_d  = 1'b1;
                out_status_d = ST_EMPTY;
                if (act_q == ACT_DUMP_FWD || act_q == ACT_DUMP_BWD) begin
                  out_value_d = '0;
                end
                state_d = S_IDLE;
              end else begin
                cur_d         = is_fwd ? head_q : tail_q;
                rd_addr       = cur_d[AddrW-1:0];
                ram_ctl.rd_en = 1'b1;
                pos_d         = One;
                state_d       = S_WALK;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_WALK: begin
        rd_addr = step_idx[AddrW-1:0];
        if (act_q == ACT_DUMP_FWD || act_q == ACT_DUMP_BWD) begin
          // One element per beat; hold the walk while the output is busy
          if (slot_free) begin
            out_valid_d  = 1'b1;
            out_status_d = ST_ELEM;
            out_value_d  = rd_val;
            out_pos_d    = is_fwd ? POS_W'(pos_q) : POS_W'(count_q - pos_q + One);
            out_last_d   = at_end;
            if (at_end) begin
              state_d = S_IDLE;
            end else begin
              ram_ctl.rd_en = 1'b1;
              cur_d         = step_idx;
              pos_d         = pos_q + One;
            end
          end
        end else if (match || at_end) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_value_d = val_q;
            out_pos_d   = '0;
            out_last_d  = 1'b1;
            state_d     = S_IDLE;
            if (!match) begin
              out_status_d = ST_NOTFOUND;
            end else if (act_q == ACT_SEARCH) begin
              out_status_d = ST_FOUND;
              out_pos_d    = POS_W'(pos_q);
            end else begin
              // Unlink the matched node
              out_status_d    = ST_DELETED;
              next_addr       = pv_idx[AddrW-1:0];
              next_wdata      = nx_idx;
              prev_addr       = nx_idx[AddrW-1:0];
              prev_wdata      = pv_idx;
              ram_ctl.next_we = (pv_idx != Nil);
              ram_ctl.prev_we = (nx_idx != Nil);
              if (pv_idx == Nil) begin
                head_d = nx_idx;
              end
              if (nx_idx == Nil) begin
                tail_d = pv_idx;
              end
              count_d = count_q - One;
              used_d[cur_q[AddrW-1:0]] = 1'b0;
            end
          end
        end else begin
          // Step to the next node
          ram_ctl.rd_en = 1'b1;
          cur_d         = step_idx;
          pos_d         = pos_q + One;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= Nil;
      tail_q      <= Nil;
      count_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    val_q        <= val_d;
    cur_q        <= cur_d;
    pos_q        <= pos_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_pos_q    <= out_pos_d;
    out_last_q   <= out_last_d;
  end

  dll_node_ram #(
    .Depth (CAPACITY),
    .IdxW  (IdxW)
  ) u_node_ram (
    .clk_i       (clk_i),
    .ctl_i       (ram_ctl),
    .val_addr_i  (val_addr),
    .val_data_i  (val_q),
    .next_addr_i (next_addr),
    .next_data_i (next_wdata),
    .prev_addr_i (prev_addr),
    .prev_data_i (prev_wdata),
    .rd_addr_i   (rd_addr),
    .rd_val_o    (rd_val),
    .rd_next_o   (rd_next),
    .rd_prev_o   (rd_prev)
  );

  // Output beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {out_pos_q, out_value_q, out_status_q};

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Nil)
    else $error("node count above capacity");

  a_used_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == 32'(count_q))
    else $error("used flags disagree with node count");

  a_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == Nil) == (count_q == '0))
    else $error("head marker disagrees with node count");

  a_walk_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (cur_q != Nil) && used_q[cur_q[AddrW-1:0]])
    else $error("walk on an unlinked node");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == S_START))
    else $error("accepted beat not started");

endmodule : doubly_linked_list_engine_core

`default_nettype wire

// ===== verif/dll_list_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// dll_list_checker - result predictor and comparator for the list engine
// Watches both stream channels. Each accepted input beat is run through a
// local model of the node store to build the expected result beats, and each
// accepted output beat is compared field by field with the oldest of them.
// ============================================================================

module dll_list_checker
  import dll_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  wire logic                   s_tvalid_i,
  input  wire logic                   s_tready_i,
  input  wire logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  wire logic                   m_tvalid_i,
  input  wire logic                   m_tlast_i,
  input  wire logic                   m_tready_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 pending_count_o
);

  localparam int unsigned NODES = CAPACITY_DEF;
  localparam logic [4:0]  NIL   = 5'(NODES);
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    status_e     status;
    logic [31:0] value;
    logic [4:0]  position;
    logic        last;
  } list_result_t;

  // Shadow copy of the node store
  logic [31:0] node_val [NODES];
  logic [4:0]  node_nxt [NODES];
  logic [4:0]  node_prv [NODES];
  logic        node_busy[NODES];
  logic [4:0]  head_idx;
  logic [4:0]  tail_idx;
  int unsigned node_total;

  list_result_t expected_results[$];
  int unsigned  mismatches;

  task automatic push_result(input status_e st, input logic [31:0] v,
                             input logic [4:0] pos, input logic last);
    list_result_t r;
    r.status   = st;
    r.value    = v;
    r.position = pos;
    r.last     = last;
    expected_results.push_back(r);
  endtask

  // First node from the head holding v; walk bounded by the store size
  task automatic find_first(input logic [31:0] v, output logic [4:0] idx,
                            output logic [4:0] pos);
    logic [4:0]  cur;
    int unsigned steps;
    cur   = head_idx;
    steps = 0;
    idx   = NIL;
    pos   = '0;
    while (cur < NIL && steps < NODES && idx == NIL) begin
      steps++;
      if (node_val[cur] == v) begin
        idx = cur;
        pos = 5'(steps);
      end else begin
        cur = node_nxt[cur];
      end
    end
  endtask

  task automatic apply_list_action(input logic [2:0] act, input logic [31:0] v);
    logic [4:0]  n;
    logic [4:0]  pos;
    logic [4:0]  nx;
    logic [4:0]  pv;
    logic [4:0]  cur;
    int unsigned k;
    logic        fwd;
    case (act)
      ACT_APPEND: begin
        n = NIL;
        if (node_total < NODES) begin
          for (int i = NODES - 1; i >= 0; i--) begin
            if (!node_busy[i]) n = 5'(i);
          end
        end
        if (n == NIL) begin
          push_result(ST_FULL, v, '0, 1'b1);
        end else begin
          node_busy[n] = 1'b1;
          node_val[n]  = v;
          node_nxt[n]  = NIL;
          node_prv[n]  = tail_idx;
          if (tail_idx < NIL) node_nxt[tail_idx] = n;
          else head_idx = n;
          tail_idx = n;
          node_total++;
          push_result(ST_ADDED, v, '0, 1'b1);
        end
      end
      ACT_SEARCH: begin
        if (head_idx >= NIL) begin
          push_result(ST_EMPTY, v, '0, 1'b1);
        end else begin
          find_first(v, n, pos);
          if (n == NIL) push_result(ST_NOTFOUND, v, '0, 1'b1);
          else push_result(ST_FOUND, v, pos, 1'b1);
        end
      end
      ACT_DELETE: begin
        if (head_idx >= NIL) begin
          push_result(ST_EMPTY, v, '0, 1'b1);
        end else begin
          find_first(v, n, pos);
          if (n == NIL) begin
            push_result(ST_NOTFOUND, v, '0, 1'b1);
          end else begin
            // unlink, fixing head/tail when the node sits at an end
            nx = node_nxt[n];
            pv = node_prv[n];
            if (pv < NIL) node_nxt[pv] = nx;
            else head_idx = nx;
            if (nx < NIL) node_prv[nx] = pv;
            else tail_idx = pv;
            node_busy[n] = 1'b0;
            node_nxt[n]  = NIL;
            node_prv[n]  = NIL;
            if (node_total > 0) node_total--;
            push_result(ST_DELETED, v, '0, 1'b1);
          end
        end
      end
      ACT_DUMP_FWD, ACT_DUMP_BWD: begin
        if (head_idx >= NIL) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          fwd = (act == ACT_DUMP_FWD);
          cur = fwd ? head_idx : tail_idx;
          k   = 0;
          while (cur < NIL && k < NODES) begin
            pos = fwd ? 5'(k + 1) : 5'(node_total - k);
            nx  = fwd ? node_nxt[cur] : node_prv[cur];
            push_result(ST_ELEM, node_val[cur], pos, !(nx < NIL && k + 1 < NODES));
            k++;
            cur = nx;
          end
        end
      end
      default: ; // unused codes: no result, no change
    endcase
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] data, input logic last);
    list_result_t exp;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: unexpected result beat: status %0d value %h pos %0d last %b",
                 $realtime, data[2:0], data[34:3], data[39:35], last);
    end else begin
      exp = expected_results.pop_front();
      if (exp.status != data[2:0] || exp.value != data[34:3] ||
          exp.position != data[39:35] || exp.last != last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result mismatch: expected st %0d val %h pos %0d last %b, got st %0d val %h pos %0d last %b",
                   $realtime, exp.status, exp.value, exp.position, exp.last,
                   data[2:0], data[34:3], data[39:35], last);
      end
    end
  endtask

  // Sample both channels on the clock edge at which a beat moves
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        node_val[i]  = '0;
        node_nxt[i]  = NIL;
        node_prv[i]  = NIL;
        node_busy[i] = 1'b0;
      end
      head_idx   = NIL;
      tail_idx   = NIL;
      node_total = 0;
      mismatches = 0;
      expected_results.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_result(m_tdata_i, m_tlast_i);
      if (s_tvalid_i && s_tready_i) apply_list_action(s_tdata_i[2:0], s_tdata_i[34:3]);
      mismatch_count_o <= mismatches;
      pending_count_o  <= expected_results.size();
    end
  end

endmodule : dll_list_checker

// ===== verif/tb_doubly_linked_list_engine_core.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_doubly_linked_list_engine_core - stimulus and verdict for the list engine
// Drives list actions into the engine with random gaps and output stalls: a
// directed pass over empty, duplicate, end-node and unused-code cases, then
// epochs that grow, shrink and churn the list. The checker does the compare.
// ============================================================================

module tb_doubly_linked_list_engine_core;
  import dll_pkg::*;

  localparam logic [2:0]  ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0]  ACT_UNUSED_HI = 3'd7;
  localparam int unsigned POOL_SIZE     = 6;
  localparam int unsigned EPOCH_ITEMS   = 41;
  localparam int unsigned EPOCHS        = 6;
  localparam int unsigned DRAIN_CYCLES  = 40;

  typedef enum int unsigned {GROW, SHRINK, CHURN} epoch_kind_e;

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tlast;
  logic                   m_tready = 1'b0;

  int unsigned mismatch_count;
  int unsigned pending_count;

  logic        gaps_on     = 1'b1;
  logic        sink_stalls = 1'b1;
  int unsigned sink_hold   = 0;
  logic [31:0] value_pool[POOL_SIZE];

  doubly_linked_list_engine_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_tdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tlast  (m_tlast),
    .m_axis_tready (m_tready)
  );

  dll_list_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tdata_i        (s_tdata),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .m_tdata_i        (m_tdata),
    .m_tvalid_i       (m_tvalid),
    .m_tlast_i        (m_tlast),
    .m_tready_i       (m_tready),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Pool values make hits and duplicates likely; the rest cover every bit
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 70) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Output back-pressure
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (sink_stalls && $urandom_range(0, 99) < 25) sink_hold <= pick_gap() + 1;
    end
  end

  // One input beat; returns at the edge where it is taken
  task automatic send_action(input logic [2:0] act, input logic [31:0] val);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tdata  <= {5'b0, val, act};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
  endtask

  initial begin
    epoch_kind_e kind;
    int unsigned sent;
    int unsigned r;
    int unsigned thr_app;
    int unsigned thr_srch;
    int unsigned thr_del;
    int unsigned thr_fwd;
    logic [2:0]  act;

    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'h8000_0000;
    value_pool[2] = 32'h7FFF_FFFF;
    for (int i = 3; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: dumps, search and delete
    send_action(ACT_DUMP_FWD, 32'h1234_5678);
    send_action(ACT_DUMP_BWD, 32'hFFFF_FFFF);
    send_action(ACT_SEARCH,   32'h8000_0000);
    send_action(ACT_DELETE,   32'h7FFF_FFFF);
    // Extreme values and a duplicate
    send_action(ACT_APPEND, 32'h8000_0000);
    send_action(ACT_APPEND, 32'h7FFF_FFFF);
    send_action(ACT_APPEND, 32'h0000_0000);
    send_action(ACT_APPEND, 32'hFFFF_FFFF);
    send_action(ACT_APPEND, 32'h5555_5555);
    send_action(ACT_APPEND, 32'h7FFF_FFFF);
    send_action(ACT_APPEND, 32'hAAAA_AAAA);
    // First match of a duplicate, then misses
    send_action(ACT_SEARCH, 32'h7FFF_FFFF);
    send_action(ACT_SEARCH, 32'h0001_2345);
    send_action(ACT_DELETE, 32'h0001_2345);
    send_action(ACT_DUMP_FWD, 32'h0);
    send_action(ACT_DUMP_BWD, 32'h0);
    // Delete at head, at tail and in the middle
    send_action(ACT_DELETE, 32'h8000_0000);
    send_action(ACT_DELETE, 32'hAAAA_AAAA);
    send_action(ACT_DELETE, 32'h0000_0000);
    send_action(ACT_DUMP_FWD, 32'h0);
    send_action(ACT_DUMP_BWD, 32'h0);
    // Unused action codes produce nothing
    for (int c = ACT_UNUSED_LO; c <= ACT_UNUSED_HI; c++) send_action(3'(c), $urandom);
    send_action(ACT_SEARCH, 32'hFFFF_FFFF);

    // Random epochs: fill to full, drain towards empty, churn
    for (int e = 0; e < EPOCHS; e++) begin
      kind = epoch_kind_e'(e % 3);
      gaps_on = ($urandom_range(0, 2) != 0);
      sink_stalls <= ($urandom_range(0, 2) != 0);
      for (int i = 3; i < POOL_SIZE; i++) value_pool[i] = $urandom;
      case (kind)
        GROW: begin
          thr_app = 70; thr_srch = 80; thr_del = 88; thr_fwd = 94;
        end
        SHRINK: begin
          thr_app = 15; thr_srch = 30; thr_del = 85; thr_fwd = 92;
        end
        default: begin
          thr_app = 35; thr_srch = 55; thr_del = 85; thr_fwd = 92;
        end
      endcase
      sent = 0;
      while (sent < EPOCH_ITEMS) begin
        if ($urandom_range(0, 99) < 2) begin
          send_action(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), $urandom);
        end else begin
          r = $urandom_range(0, 99);
          if (r < thr_app) act = ACT_APPEND;
          else if (r < thr_srch) act = ACT_SEARCH;
          else if (r < thr_del) act = ACT_DELETE;
          else if (r < thr_fwd) act = ACT_DUMP_FWD;
          else act = ACT_DUMP_BWD;
          send_action(act, pick_value());
          sent++;
        end
      end
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then let the engine settle
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule : tb_doubly_linked_list_engine_core
